[hdl/grid_point_rotate_project_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid point rotate/project block
// Shared property forms for the checker; each use expands to one assertion.
// ----------------------------------------------------------------------------
`ifndef GRID_POINT_ROTATE_PROJECT_ASSERT_SVH
`define GRID_POINT_ROTATE_PROJECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define GPRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gprp: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define GPRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gprp: next-cycle check failed");

`endif

[hdl/gprp_pkg.sv]
// ----------------------------------------------------------------------------
// gprp_pkg
// Types, constants and helper functions of the grid point rotate/project
// block: payload structs, register codes, sine table and rounding.
// ----------------------------------------------------------------------------
package gprp_pkg;

  // Screen origin and isometric projection setup
  localparam int unsigned OriginX    = 1100;
  localparam int unsigned OriginY    = 540;
  localparam int unsigned IsoOn      = 1;
  localparam int unsigned IsoDegrees = 30;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Pipeline: input, scale, centre, two stages per rotation, three for the
  // projection and the output register
  localparam int unsigned PipeDepth = 11;

  // Angle reduction: bias to a positive value that is a multiple of a turn,
  // then divide by a turn through a reciprocal
  localparam int unsigned FullTurn    = 360;
  localparam int unsigned AngleBias   = 33120;
  localparam int unsigned AngleRecip  = 93207;
  localparam int unsigned AngleShift  = 25;

  // Rounding of Q1.15 products
  localparam int unsigned FracBits  = 15;
  localparam int unsigned RoundHalf = 16384;
  localparam int unsigned RndInW    = 53;
  localparam int unsigned RndOutW   = 38;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPACING,
    CFG_HEIGHT_GAIN,
    CFG_ANGLE_X,
    CFG_ANGLE_Y,
    CFG_MAP_COLS,
    CFG_MAP_ROWS,
    CFG_PAN_X,
    CFG_PAN_Y
  } cfg_reg_e;

  typedef logic signed [16:0] trig_t;

  typedef struct packed {
    logic        [9:0]  col;
    logic        [9:0]  row;
    logic signed [15:0] elevation;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
  } out_item_t;

  // Quarter-wave sine, Q1.15, one entry per degree, 1.0 held as 32768
  localparam trig_t SinQuarter [91] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  // Sine of a whole degree in 0..359: fold into the first quadrant
  function automatic trig_t sin_deg(input logic [8:0] deg);
    logic [8:0] fold;
    logic       neg;
    fold = '0;
    neg  = 1'b0;
    if (deg <= 9'd90) begin
      fold = deg;
    end else if (deg <= 9'd180) begin
      fold = 9'd180 - deg;
    end else if (deg <= 9'd270) begin
      fold = deg - 9'd180;
      neg  = 1'b1;
    end else if (deg <= 9'd359) begin
      fold = 9'd360 - deg;
      neg  = 1'b1;
    end
    sin_deg = neg ? -SinQuarter[fold[6:0]] : SinQuarter[fold[6:0]];
  endfunction

  // Cosine as sine shifted by a quarter turn
  function automatic trig_t cos_deg(input logic [8:0] deg);
    logic [8:0] shifted;
    shifted = deg + 9'd90;
    if (shifted >= 9'(FullTurn)) begin
      shifted = shifted - 9'(FullTurn);
    end
    cos_deg = sin_deg(shifted);
  endfunction

  // Divide by 2^15, halves rounded towards plus infinity
  function automatic logic signed [RndOutW-1:0] rnd_q15(
    input logic signed [RndInW-1:0] v
  );
    logic signed [RndInW-1:0] t;
    t = v + RndInW'(RoundHalf);
    rnd_q15 = RndOutW'(t >>> FracBits);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [RndOutW-1:0] v);
    logic signed [RndOutW-1:0] hi;
    logic signed [RndOutW-1:0] lo;
    hi = 38'sd2147483647;
    lo = -38'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

  // Isometric multipliers; unity (1.0 in Q1.15) when the projection is off
  localparam int unsigned IsoIdx = ((IsoDegrees % FullTurn) + FullTurn) % FullTurn;
  localparam trig_t IsoCos  = cos_deg(9'(IsoIdx));
  localparam trig_t IsoSin  = sin_deg(9'(IsoIdx));
  localparam trig_t IsoMulX = (IsoOn != 0) ? IsoCos : trig_t'(32768);
  localparam trig_t IsoMulY = (IsoOn != 0) ? IsoSin : trig_t'(32768);

endpackage

[hdl/gprp_in_if.sv]
// ----------------------------------------------------------------------------
// gprp_in_if
// Valid/ready channel carrying one grid point per transaction.
// ----------------------------------------------------------------------------
interface gprp_in_if;
  import gprp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[hdl/gprp_out_if.sv]
// ----------------------------------------------------------------------------
// gprp_out_if
// Valid/ready channel carrying one projected point per transaction.
// ----------------------------------------------------------------------------
interface gprp_out_if;
  import gprp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[hdl/grid_point_rotate_project.sv]
// ----------------------------------------------------------------------------
// grid_point_rotate_project
// Scales, centres, rotates about X then Y, projects isometrically and offsets
// one height-map grid point to Q24.8 screen coordinates and depth.
// ----------------------------------------------------------------------------
// Takes one grid point per clock while the output side does not stall and
// returns one result per point, in order. There are eleven register stages:
// input, scale multiply, centre, rotate-about-X multiply and round,
// rotate-about-Y multiply and round, projection sum, projection multiply,
// projection round and the output register. Each stage holds its own valid
// bit and moves on as soon as the stage ahead is free, so bubbles close up
// and a stall at the output only blocks the input once every stage is full.
// Configuration writes are registered; the reduced angles and their sines
// and cosines follow through the quotient, remainder and sine/cosine registers,
// in time for a point accepted in the cycle after the write.
// ----------------------------------------------------------------------------
module grid_point_rotate_project (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gprp_in_if.sink                        in_chan,
  gprp_out_if.source                     out_chan,
  input  logic                           cfg_we_i,
  input  logic [gprp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gprp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gprp_pkg::*;

  localparam logic [7:0]  SpacingRst  = 8'd20;
  localparam logic [15:0] GainRst     = 16'd256;
  localparam logic [10:0] MapSizeRst  = 11'd1;

  // Configuration registers
  logic        [7:0]  spacing_q;
  logic        [15:0] gain_q;
  logic signed [15:0] angle_x_q;
  logic signed [15:0] angle_y_q;
  logic        [10:0] cols_q;
  logic        [10:0] rows_q;
  logic signed [15:0] pan_x_q;
  logic signed [15:0] pan_y_q;

  // Values derived from the configuration
  logic        [17:0] half_c_q, half_c_d;
  logic        [17:0] half_r_q, half_r_d;
  logic signed [25:0] off_x_q, off_x_d;
  logic signed [25:0] off_y_q, off_y_d;
  logic        [16:0] ang_u_q   [2];
  logic        [16:0] ang_u_d   [2];
  logic        [7:0]  ang_quo_q [2];
  logic        [7:0]  ang_quo_d [2];
  logic        [8:0]  ang_rem_q [2];
  logic        [8:0]  ang_rem_d [2];
  trig_t              sin_q     [2];
  trig_t              sin_d     [2];
  trig_t              cos_q     [2];
  trig_t              cos_d     [2];
  logic signed [15:0] angle_raw [2];

  // Pipeline control
  logic [PipeDepth-1:0] valid_q, valid_d;
  logic [PipeDepth-1:0] stage_en;

  // Pipeline payload
  in_item_t           s0_item_q;
  logic        [17:0] s1_colsp_q, s1_colsp_d;
  logic        [17:0] s1_rowsp_q, s1_rowsp_d;
  logic signed [32:0] s1_z_q, s1_z_d;
  logic signed [26:0] s2_x_q, s2_x_d;
  logic signed [26:0] s2_y_q, s2_y_d;
  logic signed [32:0] s2_z_q;
  logic signed [49:0] s3_yc_q, s3_yc_d;
  logic signed [49:0] s3_zs_q, s3_zs_d;
  logic signed [49:0] s3_zc_q, s3_zc_d;
  logic signed [49:0] s3_ys_q, s3_ys_d;
  logic signed [26:0] s3_x_q;
  logic signed [33:0] s4_y_q, s4_y_d;
  logic signed [33:0] s4_z_q, s4_z_d;
  logic signed [26:0] s4_x_q;
  logic signed [50:0] s5_xc_q, s5_xc_d;
  logic signed [50:0] s5_zs_q, s5_zs_d;
  logic signed [50:0] s5_zc_q, s5_zc_d;
  logic signed [50:0] s5_xs_q, s5_xs_d;
  logic signed [33:0] s5_y_q;
  logic signed [33:0] s6_x_q, s6_x_d;
  logic signed [33:0] s6_z_q, s6_z_d;
  logic signed [33:0] s6_y_q;
  logic signed [34:0] s7_dif_q, s7_dif_d;
  logic signed [34:0] s7_sum_q, s7_sum_d;
  logic signed [33:0] s7_z_q;
  logic signed [51:0] s8_pd_q, s8_pd_d;
  logic signed [51:0] s8_ps_q, s8_ps_d;
  logic signed [33:0] s8_z_q;
  logic signed [RndOutW-1:0] s9_sx_q, s9_sx_d;
  logic signed [RndOutW-1:0] s9_sy_q, s9_sy_d;
  logic signed [33:0]        s9_z_q;
  out_item_t                 out_q, out_d;

  // --------------------------------------------------------------------------
  // Configuration writes; for spacing and map size only the low data bits are kept
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SpacingRst;
      gain_q    <= GainRst;
      angle_x_q <= '0;
      angle_y_q <= '0;
      cols_q    <= MapSizeRst;
      rows_q    <= MapSizeRst;
      pan_x_q   <= '0;
      pan_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SPACING:     spacing_q <= cfg_data_i[7:0];
        CFG_HEIGHT_GAIN: gain_q    <= cfg_data_i;
        CFG_ANGLE_X:     angle_x_q <= cfg_data_i;
        CFG_ANGLE_Y:     angle_y_q <= cfg_data_i;
        CFG_MAP_COLS:    cols_q    <= cfg_data_i[10:0];
        CFG_MAP_ROWS:    rows_q    <= cfg_data_i[10:0];
        CFG_PAN_X:       pan_x_q   <= cfg_data_i;
        CFG_PAN_Y:       pan_y_q   <= cfg_data_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derive centring halves, screen offsets, sines and cosines, and reduced angles
  // --------------------------------------------------------------------------
  always_comb begin
    logic [18:0] cols_sp;
    logic [18:0] rows_sp;
    logic signed [17:0] org_x;
    logic signed [17:0] org_y;
    logic [33:0] quo_prod;
    logic [16:0] turns;
    cols_sp  = 19'(cols_q) * 19'(spacing_q);
    rows_sp  = 19'(rows_q) * 19'(spacing_q);
    half_c_d = cols_sp[18:1];
    half_r_d = rows_sp[18:1];
    org_x    = 18'(OriginX) + 18'(pan_x_q);
    org_y    = 18'(OriginY) + 18'(pan_y_q);
    off_x_d  = {org_x, 8'b0};
    off_y_d  = {org_y, 8'b0};
    angle_raw[0] = angle_x_q;
    angle_raw[1] = angle_y_q;
    for (int a = 0; a < 2; a++) begin
      // Add a bias of whole turns to make the angle positive, then take the quotient
      ang_u_d[a]   = 17'(18'(angle_raw[a]) + 18'(AngleBias));
      quo_prod     = 34'(ang_u_d[a]) * 34'(AngleRecip);
      ang_quo_d[a] = quo_prod[AngleShift +: 8];
      // Remainder from the registered quotient
      turns        = 17'(ang_quo_q[a]) * 17'(FullTurn);
      ang_rem_d[a] = 9'(ang_u_q[a] - turns);
      sin_d[a]     = sin_deg(ang_rem_q[a]);
      cos_d[a]     = cos_deg(ang_rem_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_c_q <= 18'(SpacingRst) >> 1;
      half_r_q <= 18'(SpacingRst) >> 1;
      off_x_q  <= 26'(OriginX) << 8;
      off_y_q  <= 26'(OriginY) << 8;
      for (int a = 0; a < 2; a++) begin
        ang_u_q[a]   <= 17'(AngleBias);
        ang_quo_q[a] <= 8'(AngleBias / FullTurn);
        ang_rem_q[a] <= '0;
        sin_q[a]     <= sin_deg(9'd0);
        cos_q[a]     <= cos_deg(9'd0);
      end
    end else begin
      half_c_q <= half_c_d;
      half_r_q <= half_r_d;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      for (int a = 0; a < 2; a++) begin
        ang_u_q[a]   <= ang_u_d[a];
        ang_quo_q[a] <= ang_quo_d[a];
        ang_rem_q[a] <= ang_rem_d[a];
        sin_q[a]     <= sin_d[a];
        cos_q[a]     <= cos_d[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage advances when it is empty or the next one advances
  // --------------------------------------------------------------------------
  always_comb begin
    stage_en[PipeDepth-1] = !valid_q[PipeDepth-1] || out_chan.ready;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
    valid_d[0] = stage_en[0] ? in_chan.valid : valid_q[0];
    for (int k = 1; k < PipeDepth; k++) begin
      valid_d[k] = stage_en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_chan.ready  = stage_en[0];
  assign out_chan.valid = valid_q[PipeDepth-1];
  assign out_chan.item  = out_q;

  // --------------------------------------------------------------------------
  // Datapath, one section of logic per stage
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [16:0] gain_s;
    logic signed [18:0] xd;
    logic signed [18:0] yd;
    // Scale by spacing and height gain
    gain_s     = $signed({1'b0, gain_q});
    s1_colsp_d = 18'(s0_item_q.col) * 18'(spacing_q);
    s1_rowsp_d = 18'(s0_item_q.row) * 18'(spacing_q);
    s1_z_d     = 33'(s0_item_q.elevation) * 33'(gain_s);
    // Centre on the map and move to Q.8
    xd     = $signed(19'(s1_colsp_q)) - $signed(19'(half_c_q));
    yd     = $signed(19'(s1_rowsp_q)) - $signed(19'(half_r_q));
    s2_x_d = {xd, 8'b0};
    s2_y_d = {yd, 8'b0};
    // Rotate about X: products
    s3_yc_d = 50'(s2_y_q) * 50'(cos_q[0]);
    s3_zs_d = 50'(s2_z_q) * 50'(sin_q[0]);
    s3_zc_d = 50'(s2_z_q) * 50'(cos_q[0]);
    s3_ys_d = 50'(s2_y_q) * 50'(sin_q[0]);
    // Rotate about X: sum and round
    s4_y_d = 34'(rnd_q15(RndInW'(s3_yc_q) + RndInW'(s3_zs_q)));
    s4_z_d = 34'(rnd_q15(RndInW'(s3_zc_q) - RndInW'(s3_ys_q)));
    // Rotate about Y: products
    s5_xc_d = 51'(s4_x_q) * 51'(cos_q[1]);
    s5_zs_d = 51'(s4_z_q) * 51'(sin_q[1]);
    s5_zc_d = 51'(s4_z_q) * 51'(cos_q[1]);
    s5_xs_d = 51'(s4_x_q) * 51'(sin_q[1]);
    // Rotate about Y: sum and round
    s6_x_d = 34'(rnd_q15(RndInW'(s5_xc_q) + RndInW'(s5_zs_q)));
    s6_z_d = 34'(rnd_q15(RndInW'(s5_zc_q) - RndInW'(s5_xs_q)));
    // Projection operands; pass x and y straight on without the projection
    if (IsoOn != 0) begin
      s7_dif_d = 35'(s6_x_q) - 35'(s6_y_q);
      s7_sum_d = 35'(s6_x_q) + 35'(s6_y_q);
    end else begin
      s7_dif_d = 35'(s6_x_q);
      s7_sum_d = 35'(s6_y_q);
    end
    // Projection products
    s8_pd_d = 52'(s7_dif_q) * 52'(IsoMulX);
    s8_ps_d = 52'(s7_sum_q) * 52'(IsoMulY);
    // Projection round, lift by depth when the projection is on
    s9_sx_d = rnd_q15(RndInW'(s8_pd_q));
    if (IsoOn != 0) begin
      s9_sy_d = rnd_q15(RndInW'(s8_ps_q)) - RndOutW'(s8_z_q);
    end else begin
      s9_sy_d = rnd_q15(RndInW'(s8_ps_q));
    end
    // Add origin and pan, saturate
    out_d.screen_x = sat32(s9_sx_q + RndOutW'(off_x_q));
    out_d.screen_y = sat32(s9_sy_q + RndOutW'(off_y_q));
    out_d.depth    = sat32(RndOutW'(s9_z_q));
  end

  // Hold each stage while the stage ahead is blocked
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s0_item_q <= in_chan.item;
    end
    if (stage_en[1]) begin
      s1_colsp_q <= s1_colsp_d;
      s1_rowsp_q <= s1_rowsp_d;
      s1_z_q     <= s1_z_d;
    end
    if (stage_en[2]) begin
      s2_x_q <= s2_x_d;
      s2_y_q <= s2_y_d;
      s2_z_q <= s1_z_q;
    end
    if (stage_en[3]) begin
      s3_yc_q <= s3_yc_d;
      s3_zs_q <= s3_zs_d;
      s3_zc_q <= s3_zc_d;
      s3_ys_q <= s3_ys_d;
      s3_x_q  <= s2_x_q;
    end
    if (stage_en[4]) begin
      s4_y_q <= s4_y_d;
      s4_z_q <= s4_z_d;
      s4_x_q <= s3_x_q;
    end
    if (stage_en[5]) begin
      s5_xc_q <= s5_xc_d;
      s5_zs_q <= s5_zs_d;
      s5_zc_q <= s5_zc_d;
      s5_xs_q <= s5_xs_d;
      s5_y_q  <= s4_y_q;
    end
    if (stage_en[6]) begin
      s6_x_q <= s6_x_d;
      s6_z_q <= s6_z_d;
      s6_y_q <= s5_y_q;
    end
    if (stage_en[7]) begin
      s7_dif_q <= s7_dif_d;
      s7_sum_q <= s7_sum_d;
      s7_z_q   <= s6_z_q;
    end
    if (stage_en[8]) begin
      s8_pd_q <= s8_pd_d;
      s8_ps_q <= s8_ps_d;
      s8_z_q  <= s7_z_q;
    end
    if (stage_en[9]) begin
      s9_sx_q <= s9_sx_d;
      s9_sy_q <= s9_sy_d;
      s9_z_q  <= s8_z_q;
    end
    if (stage_en[10]) begin
      out_q <= out_d;
    end
  end

endmodule

[hdl/gprp_checker.sv]
// ----------------------------------------------------------------------------
// gprp_checker
// Port-level checks of the grid point rotate/project block: in-flight count
// against the pipeline depth, output hold under stall, input flow.
// ----------------------------------------------------------------------------
`include "grid_point_rotate_project_assert.svh"

module gprp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input gprp_pkg::out_item_t out_item_i
);
  import gprp_pkg::*;

  logic [3:0] count_q, count_d;
  logic       in_fire;
  logic       out_fire;

  // Track transactions accepted but not yet delivered
  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (in_fire && !out_fire) begin
      count_d = count_q + 4'd1;
    end else if (out_fire && !in_fire) begin
      count_d = count_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Never more points in flight than pipeline stages
  `GPRP_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= 4'(PipeDepth))

  // No result without a point behind it
  `GPRP_ASSERT_NOW(a_no_invented, clk_i, rst_ni, count_q == 4'd0, !out_valid_i)

  // An empty output register leaves room for a new point
  `GPRP_ASSERT_NOW(a_flow, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A stalled result holds
  `GPRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i))

endmodule

bind grid_point_rotate_project gprp_checker u_gprp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan.valid),
  .in_ready_i  (in_chan.ready),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_item_i  (out_chan.item)
);
